FILE: src/drf_pkg.sv
`timescale 1ns / 1ps

package drf_pkg;

    // Record modes as held in the mode register; codes 5 to 7 frame nothing.
    localparam logic [2:0] MODE_TEXT     = 3'd0;
    localparam logic [2:0] MODE_FIXED    = 3'd1;
    localparam logic [2:0] MODE_VARIABLE = 3'd2;
    localparam logic [2:0] MODE_IBM_VAR  = 3'd3;
    localparam logic [2:0] MODE_IBM_SPAN = 3'd4;

    // Configuration register indexes.
    localparam logic [0:0] CFG_RECORD_MODE = 1'b0;
    localparam logic [0:0] CFG_FIXED_WIDTH = 1'b1;

    localparam int SEG_MAX     = 65527;
    localparam int MAX_BEATS   = 9;
    localparam int BEAT_IDX_W  = 4;

    localparam logic [7:0]  CHAR_NEWLINE = 8'h0a;
    localparam logic [7:0]  CHAR_SPACE   = 8'h20;
    localparam logic [15:0] BDW_EXTRA    = 16'd8;
    localparam logic [15:0] RDW_EXTRA    = 16'd4;

    // Segment control codes carried in the record descriptor word.
    localparam logic [7:0] SCC_ONLY   = 8'd0;
    localparam logic [7:0] SCC_FIRST  = 8'd1;
    localparam logic [7:0] SCC_LAST   = 8'd2;
    localparam logic [7:0] SCC_MIDDLE = 8'd3;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [15:0] out_repeat;
    } drf_beat_t;

    // Everything one input item gives: up to nine output beats and their count.
    typedef struct packed {
        drf_beat_t [MAX_BEATS-1:0] beats;
        logic [BEAT_IDX_W-1:0]     count;
    } drf_plan_t;

endpackage

FILE: src/drf_plan.sv
`timescale 1ns / 1ps

module drf_plan #(
    parameter int LENGTH_BITS = 24
) (
    input  logic [7:0]             rec_byte,
    input  logic [23:0]            rec_length,
    input  logic                   record_start,
    input  logic                   empty_record,
    input  logic [2:0]             record_mode,
    input  logic [15:0]            fixed_record_width,
    input  logic [LENGTH_BITS-1:0] offset_cur,
    input  logic [LENGTH_BITS-1:0] length_cur,
    input  logic [15:0]            fill_cur,
    output logic [LENGTH_BITS-1:0] offset_new,
    output logic [LENGTH_BITS-1:0] length_new,
    output logic [15:0]            fill_new,
    output drf_pkg::drf_plan_t     plan
);
    import drf_pkg::*;

    localparam logic [LENGTH_BITS-1:0] SEG_MAX_W = LENGTH_BITS'(SEG_MAX);
    localparam logic [LENGTH_BITS-1:0] ONE_W     = LENGTH_BITS'(1);

    logic [LENGTH_BITS-1:0] len_w;
    logic                   is_empty;
    logic [LENGTH_BITS-1:0] o;
    logic [LENGTH_BITS-1:0] lat;
    logic [15:0]            fill;
    logic [LENGTH_BITS-1:0] o_inc;
    logic                   last;
    logic [31:0]            lat32;
    logic [LENGTH_BITS-1:0] eff;
    logic [LENGTH_BITS-1:0] rest;
    logic [15:0]            chunk;
    logic [15:0]            bdw;
    logic [15:0]            rdw;
    logic                   seg_first;
    logic                   seg_fin;
    logic [7:0]             scc;
    logic [15:0]            fill_inc;
    logic                   in_width;
    logic                   pad;
    logic [15:0]            pad_count;

    function automatic drf_beat_t mk_beat(input logic [7:0] b, input logic [15:0] r);
        drf_beat_t t;
        t.out_byte   = b;
        t.out_repeat = r;
        return t;
    endfunction

    assign len_w    = LENGTH_BITS'(rec_length);
    assign is_empty = empty_record || (record_start && len_w == '0);

    // A start beat resets the record context before the byte is looked at.
    assign o     = record_start ? '0 : offset_cur;
    assign lat   = record_start ? len_w : length_cur;
    assign fill  = record_start ? 16'd0 : fill_cur;
    assign o_inc = o + ONE_W;
    assign last  = (o_inc == lat);
    assign lat32 = 32'(lat);

    assign eff       = (record_mode == MODE_IBM_VAR && lat > SEG_MAX_W) ? SEG_MAX_W : lat;
    assign rest      = eff - o;
    assign chunk     = (rest > SEG_MAX_W) ? 16'(SEG_MAX) : rest[15:0];
    assign bdw       = chunk + BDW_EXTRA;
    assign rdw       = chunk + RDW_EXTRA;
    assign seg_first = (o == '0);
    assign seg_fin   = (rest <= SEG_MAX_W);
    assign fill_inc  = fill + 16'd1;

    always_comb begin
        case ({seg_first, seg_fin})
            2'b11:   scc = SCC_ONLY;
            2'b10:   scc = SCC_FIRST;
            2'b01:   scc = SCC_LAST;
            default: scc = SCC_MIDDLE;
        endcase
    end

    assign in_width  = (32'(o) < 32'(fixed_record_width));
    assign pad       = last && (32'(lat) < 32'(fixed_record_width));
    assign pad_count = 16'(32'(fixed_record_width) - 32'(lat));

    always_comb begin
        logic [BEAT_IDX_W-1:0] base;
        base       = '0;
        plan.beats = {MAX_BEATS{mk_beat(8'd0, 16'd1)}};
        plan.count = '0;
        offset_new = offset_cur;
        length_new = length_cur;
        fill_new   = fill_cur;

        if (is_empty) begin
            offset_new = '0;
            length_new = '0;
            fill_new   = 16'd0;
            case (record_mode)
                MODE_TEXT: begin
                    plan.beats[0] = mk_beat(CHAR_NEWLINE, 16'd1);
                    plan.count    = BEAT_IDX_W'(1);
                end
                MODE_FIXED: begin
                    plan.beats[0] = mk_beat(CHAR_SPACE, fixed_record_width);
                    plan.count    = (fixed_record_width != 16'd0) ? BEAT_IDX_W'(1) : '0;
                end
                MODE_VARIABLE: begin
                    plan.count = BEAT_IDX_W'(8);
                end
                default: begin
                    plan.count = '0;
                end
            endcase
        end else if (o < lat) begin
            offset_new = o_inc;
            length_new = lat;
            fill_new   = fill;
            case (record_mode)
                MODE_TEXT: begin
                    plan.beats[0] = mk_beat(rec_byte, 16'd1);
                    plan.beats[1] = mk_beat(CHAR_NEWLINE, 16'd1);
                    plan.count    = last ? BEAT_IDX_W'(2) : BEAT_IDX_W'(1);
                end
                MODE_FIXED: begin
                    if (in_width) begin
                        plan.beats[0] = mk_beat(rec_byte, 16'd1);
                        base          = BEAT_IDX_W'(1);
                    end
                    plan.beats[base] = mk_beat(CHAR_SPACE, pad_count);
                    plan.count       = base + (pad ? BEAT_IDX_W'(1) : '0);
                end
                MODE_VARIABLE: begin
                    if (seg_first) begin
                        for (int k = 0; k < 4; k++) begin
                            plan.beats[k] = mk_beat(lat32[8*k +: 8], 16'd1);
                        end
                        base = BEAT_IDX_W'(4);
                    end
                    plan.beats[base] = mk_beat(rec_byte, 16'd1);
                    for (int k = 0; k < 4; k++) begin
                        plan.beats[base + BEAT_IDX_W'(k + 1)] =
                            mk_beat(lat32[8*k +: 8], 16'd1);
                    end
                    plan.count = base + (last ? BEAT_IDX_W'(5) : BEAT_IDX_W'(1));
                end
                MODE_IBM_VAR, MODE_IBM_SPAN: begin
                    if (o < eff) begin
                        // A new segment opens with its block and record descriptor words.
                        if (fill == 16'd0) begin
                            plan.beats[0] = mk_beat(bdw[15:8], 16'd1);
                            plan.beats[1] = mk_beat(bdw[7:0], 16'd1);
                            plan.beats[2] = mk_beat(8'd0, 16'd1);
                            plan.beats[3] = mk_beat(8'd0, 16'd1);
                            plan.beats[4] = mk_beat(rdw[15:8], 16'd1);
                            plan.beats[5] = mk_beat(rdw[7:0], 16'd1);
                            plan.beats[6] = mk_beat(scc, 16'd1);
                            plan.beats[7] = mk_beat(8'd0, 16'd1);
                            base          = BEAT_IDX_W'(8);
                        end
                        plan.beats[base] = mk_beat(rec_byte, 16'd1);
                        plan.count       = base + BEAT_IDX_W'(1);
                        if (fill_inc >= 16'(SEG_MAX) || o_inc == eff) begin
                            fill_new = 16'd0;
                        end else begin
                            fill_new = fill_inc;
                        end
                    end
                end
                default: begin
                    plan.count = '0;
                end
            endcase
        end
    end

endmodule

FILE: src/data_record_framer.sv
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// s_        in         tdata: rec_byte, rec_length; tuser: record_start, empty_record
// m_        out        tdata: out_byte, out_repeat; tlast: last beat of an input item
// cfg_      in         cfg_index selects record_mode (0) or fixed_record_width (1)
//
// An input beat is framed in the cycle it is taken and its zero to nine output beats
// leave one per cycle while m_tready is high; a beat carrying a header or trailer
// holds s_tready low until its last output beat is sent. The output register lets the
// next input beat be taken while the final output beat of the previous one waits.
// Reset is synchronous and clears the mode, width and record context.
// Stalls on m_tready hold the output beat and back-pressure s_tready.
module data_record_framer #(
    parameter int LENGTH_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [7:0] rec_byte, [31:8] rec_length
    input  logic [1:0]  s_tuser,   // [0] record_start, [1] empty_record
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] out_repeat
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import drf_pkg::*;

    logic [2:0]             mode_reg;
    logic [15:0]            width_reg;
    logic [LENGTH_BITS-1:0] offset_reg;
    logic [LENGTH_BITS-1:0] offset_next;
    logic [LENGTH_BITS-1:0] length_reg;
    logic [LENGTH_BITS-1:0] length_next;
    logic [15:0]            fill_reg;
    logic [15:0]            fill_next;
    drf_plan_t              plan_next;
    drf_plan_t              plan_reg;
    logic                   plan_valid_reg;
    logic [BEAT_IDX_W-1:0]  idx_reg;
    logic                   m_valid_reg;
    drf_beat_t              m_beat_reg;
    logic                   m_last_reg;
    logic                   out_free;
    logic                   emit;
    logic                   at_last;
    logic                   accept;

    drf_plan #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_plan (
        .rec_byte           (s_tdata[7:0]),
        .rec_length         (s_tdata[31:8]),
        .record_start       (s_tuser[0]),
        .empty_record       (s_tuser[1]),
        .record_mode        (mode_reg),
        .fixed_record_width (width_reg),
        .offset_cur         (offset_reg),
        .length_cur         (length_reg),
        .fill_cur           (fill_reg),
        .offset_new         (offset_next),
        .length_new         (length_next),
        .fill_new           (fill_next),
        .plan               (plan_next)
    );

    assign out_free  = !m_valid_reg || m_tready;
    assign emit      = plan_valid_reg && out_free;
    assign at_last   = (idx_reg == plan_reg.count - BEAT_IDX_W'(1));
    assign s_tready  = !plan_valid_reg || (emit && at_last);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_beat_reg.out_repeat, m_beat_reg.out_byte};
    assign m_tlast  = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_TEXT;
            width_reg <= 16'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_RECORD_MODE: mode_reg  <= cfg_data[2:0];
                CFG_FIXED_WIDTH: width_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg     <= '0;
            length_reg     <= '0;
            fill_reg       <= 16'd0;
            plan_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end else if (accept) begin
            offset_reg     <= offset_next;
            length_reg     <= length_next;
            fill_reg       <= fill_next;
            // An item that yields nothing leaves the plan stage empty.
            plan_valid_reg <= (plan_next.count != '0);
            idx_reg        <= '0;
        end else if (emit) begin
            if (at_last) begin
                plan_valid_reg <= 1'b0;
            end
            idx_reg <= idx_reg + BEAT_IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            plan_reg <= plan_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_beat_reg <= plan_reg.beats[idx_reg];
            m_last_reg <= at_last;
        end
    end

endmodule

FILE: verif/data_record_framer_test.sv
`timescale 1ns / 1ps

module data_record_framer_test;
    import drf_pkg::*;

    localparam int LONG_HOLD   = 200;
    localparam int SETTLE      = 20;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [7:0]  data_byte;
        logic [15:0] repeat_count;
        logic        last;
    } framed_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;     // [7:0] rec_byte, [31:8] rec_length
    logic [1:0]  s_tuser = '0;     // [0] record_start, [1] empty_record
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // [7:0] out_byte, [23:8] out_repeat
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Framing context as the block should hold it.
    logic [2:0]  mode_now = MODE_TEXT;
    logic [15:0] width_now = '0;
    logic [23:0] bytes_seen = '0;
    logic [23:0] record_len = '0;
    logic [15:0] seg_bytes = '0;

    framed_beat_t awaited_beats[$];
    framed_beat_t item_beats[$];

    bit source_gaps = 1'b1;
    bit sink_gaps = 1'b1;
    bit hold_sink = 1'b0;
    int mismatches = 0;
    int items_sent = 0;

    data_record_framer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void emit(input logic [7:0] value, input logic [15:0] count);
        framed_beat_t fb;
        fb.data_byte    = value;
        fb.repeat_count = count;
        fb.last         = 1'b0;
        item_beats.push_back(fb);
    endfunction

    function automatic void emit_le32(input logic [31:0] word);
        for (int k = 0; k < 4; k++)
            emit(word[8*k +: 8], 16'd1);
    endfunction

    // Block and record descriptor words are big-endian: length, then a third byte, then zero.
    function automatic void emit_descriptor(input logic [15:0] len_field, input logic [7:0] third);
        emit(len_field[15:8], 16'd1);
        emit(len_field[7:0], 16'd1);
        emit(third, 16'd1);
        emit(8'd0, 16'd1);
    endfunction

    function automatic void frame_item(input logic [7:0] rec_byte, input logic [23:0] rec_length,
                                       input logic record_start, input logic empty_record);
        logic [23:0] next_offset;
        logic        last_byte;
        logic [7:0]  scc;
        int unsigned usable;
        int unsigned rest;
        int unsigned chunk;
        item_beats.delete();
        if (empty_record || (record_start && rec_length == 0)) begin
            bytes_seen = '0;
            record_len = '0;
            seg_bytes  = '0;
            case (mode_now)
                MODE_TEXT: emit(CHAR_NEWLINE, 16'd1);
                MODE_FIXED: if (width_now != 0) emit(CHAR_SPACE, width_now);
                MODE_VARIABLE: begin
                    emit_le32(32'd0);
                    emit_le32(32'd0);
                end
                default: ;
            endcase
        end else begin
            if (record_start) begin
                record_len = rec_length;
                bytes_seen = '0;
                seg_bytes  = '0;
            end
            if (bytes_seen < record_len) begin
                next_offset = bytes_seen + 24'd1;
                last_byte   = (next_offset == record_len);
                case (mode_now)
                    MODE_TEXT: begin
                        emit(rec_byte, 16'd1);
                        if (last_byte) emit(CHAR_NEWLINE, 16'd1);
                    end
                    MODE_FIXED: begin
                        if (bytes_seen < width_now) emit(rec_byte, 16'd1);
                        if (last_byte && record_len < width_now)
                            emit(CHAR_SPACE, width_now - record_len[15:0]);
                    end
                    MODE_VARIABLE: begin
                        if (bytes_seen == 0) emit_le32({8'd0, record_len});
                        emit(rec_byte, 16'd1);
                        if (last_byte) emit_le32({8'd0, record_len});
                    end
                    MODE_IBM_VAR, MODE_IBM_SPAN: begin
                        usable = (mode_now == MODE_IBM_VAR && record_len > SEG_MAX) ?
                                 SEG_MAX : 32'(record_len);
                        if (bytes_seen < usable) begin
                            if (seg_bytes == 0) begin
                                rest  = usable - bytes_seen;
                                chunk = (rest > SEG_MAX) ? SEG_MAX : rest;
                                if (bytes_seen == 0)
                                    scc = (chunk == rest) ? SCC_ONLY : SCC_FIRST;
                                else
                                    scc = (chunk == rest) ? SCC_LAST : SCC_MIDDLE;
                                emit_descriptor(16'(chunk) + BDW_EXTRA, 8'd0);
                                emit_descriptor(16'(chunk) + RDW_EXTRA, scc);
                            end
                            emit(rec_byte, 16'd1);
                            seg_bytes++;
                            if (seg_bytes >= SEG_MAX || next_offset == usable)
                                seg_bytes = '0;
                        end
                    end
                    default: ;
                endcase
                bytes_seen = next_offset;
            end
        end
        if (item_beats.size() > 0)
            item_beats[item_beats.size()-1].last = 1'b1;
        foreach (item_beats[k])
            awaited_beats.push_back(item_beats[k]);
    endfunction

    task automatic send_item(input logic [7:0] rec_byte, input logic [23:0] rec_length,
                             input logic record_start, input logic empty_record);
        if (source_gaps && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rec_length, rec_byte};
        s_tuser  <= {empty_record, record_start};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        frame_item(rec_byte, rec_length, record_start, empty_record);
        items_sent++;
    endtask

    // Only the opening beat's length counts; the others carry noise there.
    task automatic send_record(input logic [23:0] rec_length, input int unsigned byte_count);
        for (int unsigned k = 0; k < byte_count; k++)
            send_item(8'($urandom), (k == 0) ? rec_length : 24'($urandom), k == 0, 1'b0);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (awaited_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] value);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_RECORD_MODE)
            mode_now = value[2:0];
        else
            width_now = value;
    endtask

    task automatic test_text_mode();
        write_reg(CFG_RECORD_MODE, 16'(MODE_TEXT));
        send_item(8'h00, 24'd3, 1'b1, 1'b0);
        send_item(8'hFF, 24'hFFFFFF, 1'b0, 1'b0);
        send_item(8'h5A, 24'd0, 1'b0, 1'b0);
        send_item(8'h11, 24'd0, 1'b0, 1'b0);           // stray byte after the record
        send_item(8'hA5, 24'd0, 1'b1, 1'b0);           // zero length start
        send_item(8'h3C, 24'hFFFFFF, 1'b1, 1'b1);      // empty record flag
        send_record(24'hFFFFFF, 2);                    // huge record, abandoned
        send_record(24'd2, 2);
        wait_for_results();
    endtask

    task automatic test_fixed_mode();
        write_reg(CFG_RECORD_MODE, 16'(MODE_FIXED));
        write_reg(CFG_FIXED_WIDTH, 16'd4);
        send_record(24'd2, 2);
        send_record(24'd6, 6);
        send_record(24'd4, 4);
        send_item(8'h00, 24'd0, 1'b0, 1'b1);
        write_reg(CFG_FIXED_WIDTH, 16'd0);
        send_item(8'h00, 24'd0, 1'b0, 1'b1);
        send_record(24'd2, 2);
        write_reg(CFG_FIXED_WIDTH, 16'hFFFF);
        send_item(8'h00, 24'd0, 1'b1, 1'b1);
        send_record(24'd1, 1);
        wait_for_results();
    endtask

    task automatic test_variable_mode();
        write_reg(CFG_RECORD_MODE, 16'(MODE_VARIABLE));
        send_record(24'd3, 3);
        send_record(24'd1, 1);
        send_item(8'hFF, 24'd0, 1'b0, 1'b1);
        wait_for_results();
    endtask

    task automatic test_ibm_and_unused_modes();
        write_reg(CFG_RECORD_MODE, 16'(MODE_IBM_VAR));
        send_record(24'd2, 2);
        send_item(8'h00, 24'd0, 1'b0, 1'b1);
        write_reg(CFG_RECORD_MODE, 16'(MODE_IBM_SPAN));
        send_record(24'd3, 3);
        send_item(8'h00, 24'd0, 1'b1, 1'b0);
        write_reg(CFG_RECORD_MODE, 16'd5);
        send_record(24'd2, 2);
        write_reg(CFG_RECORD_MODE, 16'd7);
        send_record(24'd1, 1);
        send_item(8'h00, 24'd0, 1'b0, 1'b1);
        wait_for_results();
    endtask

    // A mode change halfway through a record takes effect on the remaining bytes.
    task automatic test_mode_change_mid_record();
        write_reg(CFG_RECORD_MODE, 16'(MODE_TEXT));
        send_record(24'd5, 2);
        write_reg(CFG_RECORD_MODE, 16'(MODE_VARIABLE));
        send_item(8'h21, 24'd0, 1'b0, 1'b0);
        send_item(8'h22, 24'd0, 1'b0, 1'b0);
        write_reg(CFG_RECORD_MODE, 16'(MODE_IBM_SPAN));
        send_item(8'h23, 24'd0, 1'b0, 1'b0);
        wait_for_results();
    endtask

    task automatic test_output_stall();
        write_reg(CFG_RECORD_MODE, 16'(MODE_VARIABLE));
        hold_sink = 1'b1;
        send_record(24'd20, 20);
        wait_for_results();
    endtask

    task automatic test_random_records();
        int unsigned start_count;
        int unsigned rec_len;
        logic [2:0]  mode_pick;
        start_count = items_sent;
        while (items_sent < start_count + 40) begin
            mode_pick = 3'($urandom_range(0, 5));
            if (mode_pick == 5) mode_pick = 3'($urandom_range(5, 7));
            write_reg(CFG_RECORD_MODE, {13'($urandom), mode_pick});
            case ($urandom_range(0, 3))
                0: write_reg(CFG_FIXED_WIDTH, 16'd0);
                1: write_reg(CFG_FIXED_WIDTH, 16'hFFFF);
                default: write_reg(CFG_FIXED_WIDTH, 16'($urandom_range(1, 10)));
            endcase
            repeat (3) begin
                case ($urandom_range(0, 11))
                    0: send_item(8'($urandom), 24'($urandom), 1'($urandom), 1'b1);
                    1: send_item(8'($urandom), 24'($urandom), 1'b0, 1'b0);
                    2: send_item(8'($urandom), 24'd0, 1'b1, 1'b0);
                    3: send_record(24'($urandom), $urandom_range(1, 4));
                    default: begin
                        rec_len = $urandom_range(1, 6);
                        send_record(24'(rec_len), rec_len);
                    end
                endcase
            end
            wait_for_results();
        end
    endtask

    initial begin
        @(posedge aclk);
        forever begin
            if (hold_sink) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_sink = 1'b0;
            end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        framed_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected beat: byte=%02h repeat=%0d last=%0b",
                             $time, m_tdata[7:0], m_tdata[23:8], m_tlast);
            end else begin
                want = awaited_beats.pop_front();
                if (m_tdata[7:0] !== want.data_byte || m_tdata[23:8] !== want.repeat_count ||
                    m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: expected byte=%02h repeat=%0d last=%0b, got %02h %0d %0b",
                                 $time, want.data_byte, want.repeat_count, want.last,
                                 m_tdata[7:0], m_tdata[23:8], m_tlast);
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_text_mode();
        test_fixed_mode();
        test_variable_mode();
        test_ibm_and_unused_modes();
        test_mode_change_mid_record();
        test_random_records();
        // The closing stretch runs with no random idle bursts on either side.
        source_gaps = 1'b0;
        sink_gaps   = 1'b0;
        test_output_stall();
        wait_for_results();
        if (mismatches == 0 && awaited_beats.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
